/* src/bfbta_pkg.sv */
// shared types, constants and tag helpers for the best-fit boundary tag allocator
// no dependencies
package bfbta_pkg;

    localparam int HEAP_WORDS_DEF = 1024;
    localparam int MIN_BLOCK      = 8;
    localparam int TAG_BYTES      = 8;
    localparam int HEAP_BYTES_W   = 13;
    localparam int REQ_W          = 16;
    localparam int STATUS_W       = 2;
    localparam logic [HEAP_BYTES_W-1:0] HEAP_BYTES_RST = 13'd4096;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE    = 2'd0,
        STS_NOMEM   = 2'd1,
        STS_ZERO    = 2'd2,
        STS_IGNORED = 2'd3
    } status_t;

    localparam int NST = 42;

    typedef enum logic [NST-1:0] {
        ST_CLEAR = NST'(1) << 0,
        ST_IDLE  = NST'(1) << 1,
        ST_DONE  = NST'(1) << 2,
        ST_A_WM  = NST'(1) << 3,
        ST_A_WN  = NST'(1) << 4,
        ST_A_DEC = NST'(1) << 5,
        ST_A_S1  = NST'(1) << 6,
        ST_A_S2  = NST'(1) << 7,
        ST_A_S3  = NST'(1) << 8,
        ST_A_S4  = NST'(1) << 9,
        ST_A_T0  = NST'(1) << 10,
        ST_A_T1  = NST'(1) << 11,
        ST_A_T2  = NST'(1) << 12,
        ST_A_T3  = NST'(1) << 13,
        ST_F_H   = NST'(1) << 14,
        ST_F_L   = NST'(1) << 15,
        ST_F_R0  = NST'(1) << 16,
        ST_F_R1  = NST'(1) << 17,
        ST_F_R2  = NST'(1) << 18,
        ST_F_R3  = NST'(1) << 19,
        ST_F_L0  = NST'(1) << 20,
        ST_F_L1  = NST'(1) << 21,
        ST_F_L2  = NST'(1) << 22,
        ST_F_L3  = NST'(1) << 23,
        ST_F_L4  = NST'(1) << 24,
        ST_F_L5  = NST'(1) << 25,
        ST_F_N0  = NST'(1) << 26,
        ST_F_N1  = NST'(1) << 27,
        ST_F_N2  = NST'(1) << 28,
        ST_F_N3  = NST'(1) << 29,
        ST_F_N4  = NST'(1) << 30,
        ST_F_N5  = NST'(1) << 31,
        ST_L_A0  = NST'(1) << 32,
        ST_L_A1  = NST'(1) << 33,
        ST_L_A2  = NST'(1) << 34,
        ST_L_A3  = NST'(1) << 35,
        ST_L_A4  = NST'(1) << 36,
        ST_L_A5  = NST'(1) << 37,
        ST_L_R0  = NST'(1) << 38,
        ST_L_R1  = NST'(1) << 39,
        ST_L_R2  = NST'(1) << 40,
        ST_L_R3  = NST'(1) << 41
    } state_t;

    // magnitude of a signed tag word, free blocks are stored negated
    function automatic logic [31:0] tag_mag(input logic [31:0] w);
        return w[31] ? (32'd0 - w) : w;
    endfunction

    function automatic logic [31:0] tag_neg(input logic [31:0] m);
        return 32'd0 - m;
    endfunction

endpackage

/* src/best_fit_boundary_tag_allocator_top.sv */
// best-fit heap allocator with boundary tags over one synchronous word memory
// depends on bfbta_pkg
//
// allocate walks the free list node by node, then splits the best block or takes it whole;
// free checks the header, then merges with free neighbours or links the block
// throughput: one item at a time, set by the heap memory walk
// reset and every heap_bytes write run a format pass over all HEAP_WORDS words, no transfer taken
module best_fit_boundary_tag_allocator_top
    import bfbta_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // heap_bytes register write
    input  logic                    cfg_wr_en,
    input  logic [HEAP_BYTES_W-1:0] cfg_wr_data,
    // request channel
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // request_bytes[15:0], block_offset[28:16]
    input  logic                    s_tuser,   // action[0]
    // result channel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,   // result_offset[12:0]
    output logic [STATUS_W-1:0]     m_tuser    // status[1:0]
);

    localparam int AW        = $clog2(HEAP_WORDS);
    localparam int SW        = $clog2(HEAP_WORDS + 1);
    localparam int CAP_BYTES = HEAP_WORDS * 4;

    // usable size: rounded down to a word and capped at the memory size
    function automatic logic [HEAP_BYTES_W-1:0] fmt_usable(input logic [HEAP_BYTES_W-1:0] hb);
        logic [HEAP_BYTES_W-1:0] r;
        r = {hb[HEAP_BYTES_W-1:2], 2'b00};
        if (int'(r) > CAP_BYTES) begin
            r = HEAP_BYTES_W'(CAP_BYTES);
        end
        return r;
    endfunction

    // heap memory, one read and one write port, registered read
    logic [31:0]   heap_mem [HEAP_WORDS];
    logic [31:0]   rd_q;
    logic          rd_ok_q;
    logic          mem_re;
    logic          mem_we;
    logic [31:0]   rd_off;
    logic [31:0]   wr_off;
    logic [31:0]   wr_data;
    logic          rd_in;
    logic          wr_in;
    logic [31:0]   rdata;
    logic [31:0]   rd_m;

    // control and working registers
    state_t                  st_reg, st_next;
    state_t                  ret_reg, ret_next;
    logic [31:0]             head_reg, head_next;
    logic                    empty_reg, empty_next;
    logic [HEAP_BYTES_W-1:0] usable_reg, usable_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [SW-1:0]           steps_reg, steps_next;
    logic                    m_valid_reg, m_valid_next;
    logic [HEAP_BYTES_W-1:0] m_off_reg, m_off_next;
    logic [STATUS_W-1:0]     m_st_reg, m_st_next;
    logic [HEAP_BYTES_W-1:0] res_off_reg, res_off_next;
    logic [STATUS_W-1:0]     res_st_reg, res_st_next;
    logic [REQ_W:0]          bytes_reg, bytes_next;
    logic [31:0]             cur_reg, cur_next;
    logic [31:0]             best_reg, best_next;
    logic [31:0]             bsize_reg, bsize_next;
    logic                    found_reg, found_next;
    logic [31:0]             node_reg, node_next;
    logic [31:0]             sz_reg, sz_next;
    logic [31:0]             right_reg, right_next;
    logic [31:0]             left_reg, left_next;
    logic                    hasr_reg, hasr_next;
    logic                    hasl_reg, hasl_next;
    logic                    mr_reg, mr_next;
    logic [31:0]             nv_reg, nv_next;
    logic [31:0]             fadr_reg, fadr_next;
    logic [31:0]             mnode_reg, mnode_next;
    logic [31:0]             arg_reg, arg_next;
    logic [31:0]             tn_reg, tn_next;
    logic [31:0]             tp_reg, tp_next;

    logic [31:0]             usable32;
    logic [31:0]             bytes32;
    logic                    s_fire;
    logic                    wr_raw;

    assign usable32 = {19'd0, usable_reg};
    assign bytes32  = {15'd0, bytes_reg};
    assign s_tready = (st_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_off_reg};
    assign m_tuser  = m_st_reg;

    // out-of-range words read as zero and drop writes
    assign rd_in  = (rd_off[31:2] < 30'(HEAP_WORDS));
    assign wr_in  = (wr_off[31:2] < 30'(HEAP_WORDS));
    assign mem_we = wr_raw && wr_in;
    assign rdata  = rd_ok_q ? rd_q : 32'd0;
    assign rd_m   = tag_mag(rdata);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[wr_off[AW+1:2]] <= wr_data;
        end
        if (mem_re) begin
            rd_q    <= heap_mem[rd_off[AW+1:2]];
            rd_ok_q <= rd_in;
        end
    end

    always_comb begin
        logic [REQ_W:0]          b;
        logic [HEAP_BYTES_W-1:0] p;
        logic [31:0]             pw;
        logic [31:0]             v;
        logic                    hit;

        st_next      = st_reg;
        ret_next     = ret_reg;
        head_next    = head_reg;
        empty_next   = empty_reg;
        usable_next  = usable_reg;
        clr_next     = clr_reg;
        steps_next   = steps_reg;
        m_valid_next = m_valid_reg;
        m_off_next   = m_off_reg;
        m_st_next    = m_st_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;
        bytes_next   = bytes_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        bsize_next   = bsize_reg;
        found_next   = found_reg;
        node_next    = node_reg;
        sz_next      = sz_reg;
        right_next   = right_reg;
        left_next    = left_reg;
        hasr_next    = hasr_reg;
        hasl_next    = hasl_reg;
        mr_next      = mr_reg;
        nv_next      = nv_reg;
        fadr_next    = fadr_reg;
        mnode_next   = mnode_reg;
        arg_next     = arg_reg;
        tn_next      = tn_reg;
        tp_next      = tp_reg;
        mem_re       = 1'b0;
        rd_off       = 32'd0;
        wr_raw       = 1'b0;
        wr_off       = 32'd0;
        wr_data      = 32'd0;
        b            = '0;
        p            = s_tdata[28:16];
        pw           = {19'd0, p};
        v            = 32'd0;
        hit          = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (st_reg)
            // format pass: one free block spanning the usable heap if it holds MIN_BLOCK plus tags, rest zero
            ST_CLEAR: begin
                wr_raw = 1'b1;
                wr_off = {{(30-AW){1'b0}}, clr_reg, 2'b00};
                v      = tag_neg(usable32 - 32'(TAG_BYTES));
                if (usable32 >= 32'(MIN_BLOCK + TAG_BYTES)) begin
                    if (clr_reg == '0 ||
                        {{(32-AW){1'b0}}, clr_reg} == {21'd0, usable_reg[12:2]} - 32'd1) begin
                        wr_data = v;
                    end
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(HEAP_WORDS - 1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == ACT_ALLOC) begin
                        b = ({1'b0, s_tdata[15:0]} + 17'd3) & ~17'd3;
                        bytes_next = b;
                        if (b == '0) begin
                            res_off_next = usable_reg + HEAP_BYTES_W'(4);
                            res_st_next  = STS_ZERO;
                            st_next      = ST_DONE;
                        end else if (empty_reg || b >= {4'd0, usable_reg}) begin
                            res_off_next = '0;
                            res_st_next  = STS_NOMEM;
                            st_next      = ST_DONE;
                        end else begin
                            cur_next   = head_reg;
                            bsize_next = 32'h7fff_ffff;
                            found_next = 1'b0;
                            steps_next = '0;
                            mem_re     = 1'b1;
                            rd_off     = head_reg;
                            st_next    = ST_A_WM;
                        end
                    end else begin
                        if (p < HEAP_BYTES_W'(4) || p >= usable_reg || p[1:0] != 2'b00) begin
                            res_off_next = '0;
                            res_st_next  = STS_IGNORED;
                            st_next      = ST_DONE;
                        end else begin
                            node_next = pw - 32'd4;
                            mem_re    = 1'b1;
                            rd_off    = pw - 32'd4;
                            st_next   = ST_F_H;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_off_next   = res_off_reg;
                    m_st_next    = res_st_reg;
                    st_next      = ST_IDLE;
                end
            end
            // best-fit walk: read each node's size, then its next pointer; stop early on an exact fit
            ST_A_WM: begin
                hit = (rd_m < bsize_reg) && (rd_m >= bytes32);
                if (hit) begin
                    found_next = 1'b1;
                    bsize_next = rd_m;
                    best_next  = cur_reg;
                end
                if (hit && rd_m == bytes32) begin
                    st_next = ST_A_DEC;
                end else begin
                    mem_re  = 1'b1;
                    rd_off  = cur_reg + 32'd4;
                    st_next = ST_A_WN;
                end
            end
            ST_A_WN: begin
                cur_next   = rdata;
                steps_next = steps_reg + SW'(1);
                if (rdata == head_reg || steps_reg + SW'(1) == SW'(HEAP_WORDS)) begin
                    st_next = ST_A_DEC;
                end else begin
                    mem_re  = 1'b1;
                    rd_off  = rdata;
                    st_next = ST_A_WM;
                end
            end
            ST_A_DEC: begin
                if (!found_reg) begin
                    res_off_next = '0;
                    res_st_next  = STS_NOMEM;
                    st_next      = ST_DONE;
                end else if ({1'b0, bsize_reg} >= {1'b0, bytes32} + 33'(MIN_BLOCK + TAG_BYTES)) begin
                    left_next = bsize_reg - bytes32 - 32'(TAG_BYTES);
                    fadr_next = best_reg + bsize_reg - bytes32;
                    st_next   = ST_A_S1;
                end else begin
                    st_next = ST_A_T0;
                end
            end
            // split: allocation cut from the right end
            ST_A_S1: begin
                wr_raw  = 1'b1;
                wr_off  = fadr_reg;
                wr_data = bytes32;
                st_next = ST_A_S2;
            end
            ST_A_S2: begin
                wr_raw  = 1'b1;
                wr_off  = fadr_reg + 32'd4 + bytes32;
                wr_data = bytes32;
                st_next = ST_A_S3;
            end
            ST_A_S3: begin
                wr_raw  = 1'b1;
                wr_off  = best_reg;
                wr_data = tag_neg(left_reg);
                st_next = ST_A_S4;
            end
            ST_A_S4: begin
                wr_raw       = 1'b1;
                wr_off       = best_reg + 32'd4 + left_reg;
                wr_data      = tag_neg(left_reg);
                res_off_next = HEAP_BYTES_W'(fadr_reg + 32'd4);
                res_st_next  = STS_DONE;
                st_next      = ST_DONE;
            end
            // whole block taken
            ST_A_T0: begin
                mem_re  = 1'b1;
                rd_off  = best_reg;
                st_next = ST_A_T1;
            end
            ST_A_T1: begin
                fadr_next = best_reg + 32'd4 + rd_m;
                wr_raw    = 1'b1;
                wr_off    = best_reg;
                wr_data   = tag_neg(rdata);
                st_next   = ST_A_T2;
            end
            ST_A_T2: begin
                mem_re  = 1'b1;
                rd_off  = fadr_reg;
                st_next = ST_A_T3;
            end
            ST_A_T3: begin
                wr_raw       = 1'b1;
                wr_off       = fadr_reg;
                wr_data      = tag_neg(rdata);
                res_off_next = HEAP_BYTES_W'(best_reg + 32'd4);
                res_st_next  = STS_DONE;
                arg_next     = best_reg;
                ret_next     = ST_DONE;
                st_next      = ST_L_R0;
            end
            // free: header check, then neighbour lookup
            ST_F_H: begin
                if (rdata[31] || rdata == 32'd0 || rdata[1:0] != 2'b00 ||
                    rdata > usable32 - node_reg - 32'(TAG_BYTES)) begin
                    res_off_next = '0;
                    res_st_next  = STS_IGNORED;
                    st_next      = ST_DONE;
                end else begin
                    sz_next    = rdata;
                    right_next = node_reg + 32'(TAG_BYTES) + rdata;
                    hasr_next  = (node_reg + 32'(TAG_BYTES) + rdata) < usable32;
                    hasl_next  = node_reg >= 32'd4;
                    mr_next    = 1'b0;
                    if (node_reg >= 32'd4) begin
                        mem_re  = 1'b1;
                        rd_off  = node_reg - 32'd4;
                        st_next = ST_F_L;
                    end else begin
                        st_next = ST_F_R0;
                    end
                end
            end
            ST_F_L: begin
                left_next = node_reg - 32'(TAG_BYTES) - rd_m;
                st_next   = ST_F_R0;
            end
            ST_F_R0: begin
                if (hasr_reg) begin
                    mem_re  = 1'b1;
                    rd_off  = right_reg;
                    st_next = ST_F_R1;
                end else begin
                    st_next = ST_F_L0;
                end
            end
            ST_F_R1: begin
                if (rdata[31]) begin
                    nv_next   = tag_neg(sz_reg + rd_m + 32'(TAG_BYTES));
                    fadr_next = right_reg + 32'd4 + rd_m;
                    mr_next   = 1'b1;
                    wr_raw    = 1'b1;
                    wr_off    = node_reg;
                    wr_data   = tag_neg(sz_reg + rd_m + 32'(TAG_BYTES));
                    arg_next  = node_reg;
                    ret_next  = ST_F_R2;
                    st_next   = ST_L_A0;
                end else begin
                    st_next = ST_F_L0;
                end
            end
            ST_F_R2: begin
                arg_next = right_reg;
                ret_next = ST_F_R3;
                st_next  = ST_L_R0;
            end
            ST_F_R3: begin
                wr_raw  = 1'b1;
                wr_off  = fadr_reg;
                wr_data = nv_reg;
                st_next = ST_F_L0;
            end
            ST_F_L0: begin
                if (hasl_reg) begin
                    mem_re  = 1'b1;
                    rd_off  = left_reg;
                    st_next = ST_F_L1;
                end else begin
                    st_next = ST_F_N0;
                end
            end
            ST_F_L1: begin
                if (rdata[31]) begin
                    if (mr_reg) begin
                        arg_next = node_reg;
                        ret_next = ST_F_L2;
                        st_next  = ST_L_R0;
                    end else begin
                        st_next = ST_F_L2;
                    end
                end else begin
                    st_next = ST_F_N0;
                end
            end
            ST_F_L2: begin
                mem_re  = 1'b1;
                rd_off  = node_reg;
                st_next = ST_F_L3;
            end
            ST_F_L3: begin
                fadr_next  = node_reg + 32'd4 + rd_m;
                mnode_next = rd_m;
                mem_re     = 1'b1;
                rd_off     = left_reg;
                st_next    = ST_F_L4;
            end
            ST_F_L4: begin
                nv_next = tag_neg(mnode_reg + rd_m + 32'(TAG_BYTES));
                wr_raw  = 1'b1;
                wr_off  = left_reg;
                wr_data = tag_neg(mnode_reg + rd_m + 32'(TAG_BYTES));
                st_next = ST_F_L5;
            end
            ST_F_L5: begin
                wr_raw       = 1'b1;
                wr_off       = fadr_reg;
                wr_data      = nv_reg;
                res_off_next = '0;
                res_st_next  = STS_DONE;
                st_next      = ST_DONE;
            end
            // no left merge: finish after a right merge, else link the block and flip both tags to free
            ST_F_N0: begin
                if (mr_reg) begin
                    res_off_next = '0;
                    res_st_next  = STS_DONE;
                    st_next      = ST_DONE;
                end else begin
                    mem_re  = 1'b1;
                    rd_off  = node_reg;
                    st_next = ST_F_N1;
                end
            end
            ST_F_N1: begin
                fadr_next = node_reg + 32'd4 + rd_m;
                arg_next  = node_reg;
                ret_next  = ST_F_N2;
                st_next   = ST_L_A0;
            end
            ST_F_N2: begin
                mem_re  = 1'b1;
                rd_off  = node_reg;
                st_next = ST_F_N3;
            end
            ST_F_N3: begin
                wr_raw  = 1'b1;
                wr_off  = node_reg;
                wr_data = tag_neg(rdata);
                st_next = ST_F_N4;
            end
            ST_F_N4: begin
                mem_re  = 1'b1;
                rd_off  = fadr_reg;
                st_next = ST_F_N5;
            end
            ST_F_N5: begin
                wr_raw       = 1'b1;
                wr_off       = fadr_reg;
                wr_data      = tag_neg(rdata);
                res_off_next = '0;
                res_st_next  = STS_DONE;
                st_next      = ST_DONE;
            end
            // list insert before head, returns to ret_reg
            ST_L_A0: begin
                if (empty_reg) begin
                    head_next  = arg_reg;
                    empty_next = 1'b0;
                    wr_raw     = 1'b1;
                    wr_off     = arg_reg + 32'd4;
                    wr_data    = arg_reg;
                    st_next    = ST_L_A1;
                end else begin
                    mem_re  = 1'b1;
                    rd_off  = head_reg + 32'd8;
                    st_next = ST_L_A2;
                end
            end
            ST_L_A1: begin
                wr_raw  = 1'b1;
                wr_off  = arg_reg + 32'd8;
                wr_data = arg_reg;
                st_next = ret_reg;
            end
            ST_L_A2: begin
                tp_next = rdata;
                wr_raw  = 1'b1;
                wr_off  = arg_reg + 32'd4;
                wr_data = head_reg;
                st_next = ST_L_A3;
            end
            ST_L_A3: begin
                wr_raw  = 1'b1;
                wr_off  = arg_reg + 32'd8;
                wr_data = tp_reg;
                st_next = ST_L_A4;
            end
            ST_L_A4: begin
                wr_raw  = 1'b1;
                wr_off  = tp_reg + 32'd4;
                wr_data = arg_reg;
                st_next = ST_L_A5;
            end
            ST_L_A5: begin
                wr_raw  = 1'b1;
                wr_off  = head_reg + 32'd8;
                wr_data = arg_reg;
                st_next = ret_reg;
            end
            // list unlink, returns to ret_reg
            ST_L_R0: begin
                if (empty_reg) begin
                    st_next = ret_reg;
                end else begin
                    mem_re  = 1'b1;
                    rd_off  = arg_reg + 32'd4;
                    st_next = ST_L_R1;
                end
            end
            ST_L_R1: begin
                tn_next = rdata;
                if (rdata == arg_reg) begin
                    empty_next = 1'b1;
                    head_next  = 32'd0;
                    st_next    = ret_reg;
                end else begin
                    if (arg_reg == head_reg) begin
                        head_next = rdata;
                    end
                    mem_re  = 1'b1;
                    rd_off  = arg_reg + 32'd8;
                    st_next = ST_L_R2;
                end
            end
            ST_L_R2: begin
                tp_next = rdata;
                wr_raw  = 1'b1;
                wr_off  = tn_reg + 32'd8;
                wr_data = rdata;
                st_next = ST_L_R3;
            end
            ST_L_R3: begin
                wr_raw  = 1'b1;
                wr_off  = tp_reg + 32'd4;
                wr_data = tn_reg;
                st_next = ret_reg;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // heap_bytes write reformats the heap
        if (cfg_wr_en) begin
            usable_next = fmt_usable(cfg_wr_data);
            empty_next  = fmt_usable(cfg_wr_data) < HEAP_BYTES_W'(MIN_BLOCK + TAG_BYTES);
            head_next   = 32'd0;
            clr_next    = '0;
            st_next     = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLEAR;
            ret_reg     <= ST_IDLE;
            head_reg    <= 32'd0;
            usable_reg  <= fmt_usable(HEAP_BYTES_RST);
            empty_reg   <= fmt_usable(HEAP_BYTES_RST) < HEAP_BYTES_W'(MIN_BLOCK + TAG_BYTES);
            clr_reg     <= '0;
            steps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            ret_reg     <= ret_next;
            head_reg    <= head_next;
            usable_reg  <= usable_next;
            empty_reg   <= empty_next;
            clr_reg     <= clr_next;
            steps_reg   <= steps_next;
            m_valid_reg <= m_valid_next;
        end
        m_off_reg   <= m_off_next;
        m_st_reg    <= m_st_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        bytes_reg   <= bytes_next;
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        bsize_reg   <= bsize_next;
        found_reg   <= found_next;
        node_reg    <= node_next;
        sz_reg      <= sz_next;
        right_reg   <= right_next;
        left_reg    <= left_next;
        hasr_reg    <= hasr_next;
        hasl_reg    <= hasl_next;
        mr_reg      <= mr_next;
        nv_reg      <= nv_next;
        fadr_reg    <= fadr_next;
        mnode_reg   <= mnode_next;
        arg_reg     <= arg_next;
        tn_reg      <= tn_next;
        tp_reg      <= tp_next;
    end

`ifndef NO_ASSERTIONS
    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (head_reg == 32'd0))
        else $error("empty free list with nonzero head");
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= SW'(HEAP_WORDS))
        else $error("free-list walk overran its bound");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (st_reg != ST_IDLE))
        else $error("accepted transfer did not start work");
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (st_reg == ST_CLEAR))
        else $error("heap_bytes write did not start format pass");
`endif

endmodule
